@@ design/scr_pkg.sv @@
// ----------------------------------------------------------------------------
// scr_pkg
// Shared types and codes for the seam carving resizer.
// ----------------------------------------------------------------------------
package scr_pkg;

  localparam int CH_W   = 8;   // one colour channel
  localparam int CFG_W  = 9;   // configuration register width
  localparam int DIST_W = 10;  // L1 colour distance, up to 3 * 255
  localparam int ENGY_W = 11;  // pixel energy, up to 6 * 255
  localparam int EMAX   = 1530;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_IMAGE_WIDTH   = 2'd0;
  localparam cfg_idx_t CFG_IMAGE_HEIGHT  = 2'd1;
  localparam cfg_idx_t CFG_TARGET_WIDTH  = 2'd2;
  localparam cfg_idx_t CFG_TARGET_HEIGHT = 2'd3;

  // request operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  // path predecessor codes
  typedef logic [1:0] path_t;
  localparam path_t PATH_CENTER = 2'd0;
  localparam path_t PATH_LEFT   = 2'd1;
  localparam path_t PATH_RIGHT  = 2'd2;

endpackage

@@ design/scr_dist.sv @@
// ----------------------------------------------------------------------------
// scr_dist
// L1 colour distance between two pixels: the shared arithmetic unit.
// ----------------------------------------------------------------------------
module scr_dist import scr_pkg::*; (
  input  rgb_t              a,
  input  rgb_t              b,
  output logic [DIST_W-1:0] diff
);

  logic [CH_W-1:0] dr, dg, db;

  assign dr = (a.r > b.r) ? (a.r - b.r) : (b.r - a.r);
  assign dg = (a.g > b.g) ? (a.g - b.g) : (b.g - a.g);
  assign db = (a.b > b.b) ? (a.b - b.b) : (b.b - a.b);
  assign diff = DIST_W'(dr) + DIST_W'(dg) + DIST_W'(db);

endmodule

@@ design/seam_carving_resizer_unit.sv @@
// ----------------------------------------------------------------------------
// seam_carving_resizer_unit
// Content-aware image shrink by vertical, then horizontal, seam removal.
// ----------------------------------------------------------------------------
// Load an image_width x image_height RGB image one pixel per request in
// row-major order (operation 0); sizes are sampled on the first pixel.
// After the last pixel the block carves and holds in_stall high: vertical
// seams come off until the width reaches target_width, then horizontal
// seams (transposed addressing) until the height reaches target_height.
// Each seam pass over a w x h view picks the direction, then for every pixel
// computes the energy (four energy reads through the single pixel memory
// read port) and, below the first row, the path cost (three cost-row reads);
// then it scans for the minimum and backtracks row by row, moving pixels
// to squeeze the seam out of each row. Then the carved image is read out
// one pixel per readout request (operation 1), with last_pixel on the final
// one. A load during readout starts a new image; a readout request while
// loading is taken and gives nothing.
// There is no clearing pass: memories hold whatever was last written.
// ----------------------------------------------------------------------------
module seam_carving_resizer_unit import scr_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic             clk,
  input  logic             rst,
  // configuration
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  // request channel
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             operation,
  input  logic [CH_W-1:0]  red_in,
  input  logic [CH_W-1:0]  green_in,
  input  logic [CH_W-1:0]  blue_in,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CH_W-1:0]  red_out,
  output logic [CH_W-1:0]  green_out,
  output logic [CH_W-1:0]  blue_out,
  output logic             last_pixel
);

  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int XW      = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;  // coordinate
  localparam int DW      = $clog2(MAX_DIM + 1);                   // size
  localparam int AW      = $clog2(MAX_WIDTH * MAX_HEIGHT);       // pixel address
  localparam int CAW     = XW + 1;                               // cost address
  localparam int CDEPTH  = 2 << XW;
  localparam int CW      = $clog2(EMAX * MAX_DIM + 1);           // path cost

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHECK, ST_E, ST_C, ST_NEXT, ST_MIN, ST_MIN_DONE,
    ST_SH_RD, ST_SH_WR, ST_BT, ST_BT_UPD, ST_PASS_END
  } state_t;

  state_t state;

  // memories
  rgb_t          pix_mem  [MAX_WIDTH*MAX_HEIGHT];
  path_t         path_mem [MAX_WIDTH*MAX_HEIGHT];
  logic [CW-1:0] cost_mem [CDEPTH];

  rgb_t          pm_rdata;
  path_t         pth_rdata;
  logic [CW-1:0] cm_rdata;

  logic          pm_re, pm_we, pth_re, pth_we, cm_re, cm_we;
  logic [AW-1:0] pm_raddr, pm_waddr, pth_raddr, pth_waddr;
  rgb_t          pm_wdata;
  path_t         pth_wdata;
  logic [CAW-1:0] cm_raddr, cm_waddr;
  logic [CW-1:0] cm_wdata;

  // configuration and sizes
  logic [CFG_W-1:0] image_width, image_height, target_width, target_height;
  logic [CFG_W-1:0] tw, th;           // targets sampled at carve start
  logic [DW-1:0]    cur_w, cur_h;
  logic             reading;
  logic [XW-1:0]    cx, cy;           // pixel counter as column / row

  // carving pass
  logic             tr;               // transposed view
  logic [DW-1:0]    lw, lh;           // logical view size
  logic [XW-1:0]    x, y, s, shx;
  logic [2:0]       k;
  logic             cb;               // bank of the current cost row
  rgb_t             pa;
  logic [ENGY_W-1:0] esum;
  logic [CW-1:0]    best;
  path_t            pc;
  logic [DW-1:0]    mx;
  logic [XW-1:0]    bx;

  // shared distance unit
  logic [DIST_W-1:0] pair_diff;
  scr_dist u_dist (.a(pa), .b(pm_rdata), .diff(pair_diff));

  function automatic logic [AW-1:0] slot(input logic t, input logic [XW-1:0] a,
                                         input logic [XW-1:0] b);
    int r, c;
    r = t ? int'(a) : int'(b);
    c = t ? int'(b) : int'(a);
    return AW'(r * MAX_WIDTH + c);
  endfunction

  function automatic logic [DW-1:0] sat_dim(input logic [CFG_W-1:0] v, input int lim);
    logic [DW-1:0] res;
    if (v == '0)
      res = DW'(1);
    else if (int'(v) > lim)
      res = DW'(lim);
    else
      res = DW'(v);
    return res;
  endfunction

  // request side decode
  logic          in_acc, ld_acc, rd_acc, first;
  logic [XW-1:0] zx, zy;
  logic [DW-1:0] ldw, ldh;
  logic          ld_end, rd_last;

  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign ld_acc   = in_acc && (operation == OP_LOAD);
  assign rd_acc   = in_acc && (operation == OP_READ) && reading;
  assign zx       = reading ? '0 : cx;
  assign zy       = reading ? '0 : cy;
  assign first    = (zx == '0) && (zy == '0);
  assign ldw      = first ? sat_dim(image_width, MAX_WIDTH) : cur_w;
  assign ldh      = first ? sat_dim(image_height, MAX_HEIGHT) : cur_h;
  assign ld_end   = (DW'(zx) + DW'(1) == ldw) && (DW'(zy) + DW'(1) == ldh);
  assign rd_last  = (DW'(cx) + DW'(1) == cur_w) && (DW'(cy) + DW'(1) == cur_h);

  // neighbor coordinates with edge replication
  logic [XW-1:0] xl, xr, yu, yd;
  logic          has_l, has_r;
  assign has_l = (x != '0);
  assign has_r = (DW'(x) + DW'(1) < lw);
  assign xl    = has_l ? x - XW'(1) : x;
  assign xr    = has_r ? x + XW'(1) : x;
  assign yu    = (y != '0) ? y - XW'(1) : y;
  assign yd    = (DW'(y) + DW'(1) < lh) ? y + XW'(1) : y;

  logic [ENGY_W-1:0] e_fin;
  logic              r_win;
  logic [CW-1:0]     best_fin;
  logic              min_upd;
  logic              sh_more;
  logic [XW-1:0]     s_next;
  assign e_fin    = esum + ENGY_W'(pair_diff);
  assign r_win    = has_r && (cm_rdata < best);
  assign best_fin = r_win ? cm_rdata : best;
  assign min_upd  = (mx == DW'(1)) || (cm_rdata < best);
  assign sh_more  = (DW'(shx) + DW'(1) < lw);

  always_comb begin
    priority if (pth_rdata == PATH_LEFT && s != '0)
      s_next = s - XW'(1);
    else if (pth_rdata == PATH_RIGHT && DW'(s) + DW'(1) < lw)
      s_next = s + XW'(1);
    else
      s_next = s;
  end

  // memory port selection
  always_comb begin
    pm_re     = 1'b0;
    pm_raddr  = slot(1'b0, cx, cy);
    pm_we     = 1'b0;
    pm_waddr  = slot(1'b0, zx, zy);
    pm_wdata  = '{r: red_in, g: green_in, b: blue_in};
    cm_re     = 1'b0;
    cm_raddr  = {~cb, x};
    cm_we     = 1'b0;
    cm_waddr  = {cb, x};
    cm_wdata  = CW'(e_fin);
    pth_we    = 1'b0;
    pth_waddr = slot(tr, x, y);
    pth_wdata = PATH_CENTER;
    pth_re    = 1'b0;
    pth_raddr = slot(tr, s, y);
    unique case (state)
      ST_IDLE: begin
        pm_re = rd_acc;
        pm_we = ld_acc;
      end
      ST_E: begin
        pm_re = (k < 3'd4);
        unique case (k)
          3'd0:    pm_raddr = slot(tr, xl, y);
          3'd1:    pm_raddr = slot(tr, xr, y);
          3'd2:    pm_raddr = slot(tr, x, yu);
          default: pm_raddr = slot(tr, x, yd);
        endcase
        if (k == 3'd4 && y == '0) begin
          cm_we  = 1'b1;
          pth_we = 1'b1;
        end
      end
      ST_C: begin
        cm_re = (k < 3'd3);
        unique case (k)
          3'd0:    cm_raddr = {~cb, x};
          3'd1:    cm_raddr = {~cb, xl};
          default: cm_raddr = {~cb, xr};
        endcase
        if (k == 3'd3) begin
          cm_we     = 1'b1;
          cm_wdata  = CW'(esum) + best_fin;
          pth_we    = 1'b1;
          pth_wdata = r_win ? PATH_RIGHT : pc;
        end
      end
      ST_MIN: begin
        cm_re    = (mx < lw);
        cm_raddr = {~cb, mx[XW-1:0]};
      end
      ST_SH_RD: begin
        pm_re    = sh_more;
        pm_raddr = slot(tr, shx + XW'(1), y);
      end
      ST_SH_WR: begin
        pm_we    = 1'b1;
        pm_waddr = slot(tr, shx, y);
        pm_wdata = pm_rdata;
      end
      ST_BT: pth_re = (y != '0);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pm_we)
      pix_mem[pm_waddr] <= pm_wdata;
    if (pm_re)
      pm_rdata <= pix_mem[pm_raddr];
    if (pth_we)
      path_mem[pth_waddr] <= pth_wdata;
    if (pth_re)
      pth_rdata <= path_mem[pth_raddr];
    if (cm_we)
      cost_mem[cm_waddr] <= cm_wdata;
    if (cm_re)
      cm_rdata <= cost_mem[cm_raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= CFG_W'(256);
      image_height  <= CFG_W'(256);
      target_width  <= CFG_W'(256);
      target_height <= CFG_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:   image_width   <= cfg_data;
        CFG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        CFG_TARGET_WIDTH:  target_width  <= cfg_data;
        CFG_TARGET_HEIGHT: target_height <= cfg_data;
      endcase
    end
  end

  // result registers: payload comes straight from the pixel read register
  assign red_out   = pm_rdata.r;
  assign green_out = pm_rdata.g;
  assign blue_out  = pm_rdata.b;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      reading    <= 1'b0;
      cx         <= '0;
      cy         <= '0;
      cur_w      <= '0;
      cur_h      <= '0;
      out_valid  <= 1'b0;
      last_pixel <= 1'b0;
      tr         <= 1'b0;
      cb         <= 1'b0;
      k          <= '0;
      mx         <= '0;
      x          <= '0;
      y          <= '0;
      lw         <= '0;
      lh         <= '0;
    end else begin
      if (in_acc || !out_stall)
        out_valid <= rd_acc;
      unique case (state)
        ST_IDLE: begin
          if (ld_acc) begin
            reading <= 1'b0;
            cur_w   <= ldw;
            cur_h   <= ldh;
            if (ld_end) begin
              cx    <= '0;
              cy    <= '0;
              tw    <= (target_width == '0) ? CFG_W'(1) : target_width;
              th    <= (target_height == '0) ? CFG_W'(1) : target_height;
              state <= ST_CHECK;
            end else if (DW'(zx) + DW'(1) < ldw) begin
              cx <= zx + XW'(1);
              cy <= zy;
            end else begin
              cx <= '0;
              cy <= zy + XW'(1);
            end
          end else if (rd_acc) begin
            last_pixel <= rd_last;
            if (rd_last) begin
              reading <= 1'b0;
              cx      <= '0;
              cy      <= '0;
            end else if (DW'(cx) + DW'(1) < cur_w) begin
              cx <= cx + XW'(1);
            end else begin
              cx <= '0;
              cy <= cy + XW'(1);
            end
          end
        end
        ST_CHECK: begin
          x  <= '0;
          y  <= '0;
          k  <= '0;
          cb <= 1'b0;
          priority if (int'(cur_w) > int'(tw)) begin
            tr    <= 1'b0;
            lw    <= cur_w;
            lh    <= cur_h;
            state <= ST_E;
          end else if (int'(cur_h) > int'(th)) begin
            tr    <= 1'b1;
            lw    <= cur_h;
            lh    <= cur_w;
            state <= ST_E;
          end else begin
            reading <= 1'b1;
            state   <= ST_IDLE;
          end
        end
        ST_E: begin
          // horizontal pair, then vertical pair, through the one distance unit
          k <= (k == 3'd4) ? 3'd0 : k + 3'd1;
          unique case (k)
            3'd1, 3'd3: pa <= pm_rdata;
            3'd2:       esum <= ENGY_W'(pair_diff);
            3'd4: begin
              esum  <= e_fin;
              state <= (y == '0) ? ST_NEXT : ST_C;
            end
            default: ;
          endcase
        end
        ST_C: begin
          // centre first, then left, then right; only strictly cheaper wins
          k <= k + 3'd1;
          unique case (k)
            3'd1: begin
              best <= cm_rdata;
              pc   <= PATH_CENTER;
            end
            3'd2: begin
              if (has_l && cm_rdata < best) begin
                best <= cm_rdata;
                pc   <= PATH_LEFT;
              end
            end
            3'd3: state <= ST_NEXT;
            default: ;
          endcase
        end
        ST_NEXT: begin
          k <= '0;
          if (has_r) begin
            x     <= x + XW'(1);
            state <= ST_E;
          end else begin
            cb <= ~cb;
            x  <= '0;
            if (DW'(y) + DW'(1) < lh) begin
              y     <= y + XW'(1);
              state <= ST_E;
            end else begin
              mx    <= '0;
              state <= ST_MIN;
            end
          end
        end
        ST_MIN: begin
          // leftmost minimum of the last cost row
          if (mx != '0 && min_upd) begin
            best <= cm_rdata;
            bx   <= XW'(mx - DW'(1));
          end
          mx <= mx + DW'(1);
          if (mx == lw)
            state <= ST_MIN_DONE;
        end
        ST_MIN_DONE: begin
          s     <= bx;
          shx   <= bx;
          state <= ST_SH_RD;
        end
        ST_SH_RD: state <= sh_more ? ST_SH_WR : ST_BT;
        ST_SH_WR: begin
          shx   <= shx + XW'(1);
          state <= ST_SH_RD;
        end
        ST_BT: state <= (y == '0) ? ST_PASS_END : ST_BT_UPD;
        ST_BT_UPD: begin
          s     <= s_next;
          shx   <= s_next;
          y     <= y - XW'(1);
          state <= ST_SH_RD;
        end
        ST_PASS_END: begin
          if (tr)
            cur_h <= cur_h - DW'(1);
          else
            cur_w <= cur_w - DW'(1);
          state <= ST_CHECK;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a carve only starts once any pending result has been taken
  a_no_result_while_carving: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !out_valid)
    else $error("result pending while carving");

  // a pass only runs on a view wider than its target, so at least two columns
  a_pass_width: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && state != ST_CHECK) |-> (lw > DW'(1)))
    else $error("seam pass on a one-column view");

  // the column walk never leaves the view
  a_column_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_E || state == ST_C) |-> (DW'(x) < lw && DW'(y) < lh))
    else $error("carve coordinate out of range");

  // the last pixel of a readout returns the block to loading
  a_last_ends_readout: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_pixel) |-> !reading)
    else $error("readout still active after last pixel");

endmodule
